[hdl/atl_pkg.sv]
// ----------------------------------------------------------------------------
// Assembler token lexer package
// Shared result type, token kind codes, error codes, line limit and queue sizing.
// ----------------------------------------------------------------------------
package atl_pkg;

	// Token kinds carried by every result.
	localparam logic [3:0] KIND_TEXT     = 4'd0;
	localparam logic [3:0] KIND_IDENT    = 4'd1;
	localparam logic [3:0] KIND_INT      = 4'd2;
	localparam logic [3:0] KIND_FLOAT    = 4'd3;
	localparam logic [3:0] KIND_LABEL    = 4'd4;
	localparam logic [3:0] KIND_LABELDEF = 4'd5;
	localparam logic [3:0] KIND_LOCAL    = 4'd6;
	localparam logic [3:0] KIND_LOCALDEF = 4'd7;
	localparam logic [3:0] KIND_EXTFUN   = 4'd8;
	localparam logic [3:0] KIND_STRING   = 4'd9;
	localparam logic [3:0] KIND_NEWLINE  = 4'd10;
	localparam logic [3:0] KIND_EOF      = 4'd11;
	localparam logic [3:0] KIND_ERROR    = 4'd12;

	// Error codes for error results.
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_UNDEF_CHAR = 3'd1;
	localparam logic [2:0] ERR_UNTERM_STR = 3'd2;
	localparam logic [2:0] ERR_OCTAL_ESC  = 3'd3;
	localparam logic [2:0] ERR_ESC_NL     = 3'd4;

	// Line counter saturation value.
	localparam logic [23:0] LINE_MAX = 24'hFF_FFFF;

	// Result queue sizing.
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = 2;

	// One result transaction.
	typedef struct packed {
		logic [3:0]  kind;
		logic [7:0]  text;
		logic [2:0]  err;
		logic [23:0] line;
		logic        last;
	} result_t;

endpackage

[hdl/atl_lex_core.sv]
// ----------------------------------------------------------------------------
// Assembler token lexer core
// Lexer state machine and line counter. Classifies one character per cycle
// while consume is high and produces up to two results, including the
// reprocessing pass for a character that ends a token without belonging to it.
// ----------------------------------------------------------------------------
module atl_lex_core
	import atl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       consume,
	input  logic [7:0] char_s1,
	input  logic       eoi_s1,
	output logic [1:0] push_cnt,
	output result_t    res0,
	output result_t    res1
);

	typedef enum logic [10:0] {
		ST_READY     = 11'b000_0000_0001,
		ST_IDENT     = 11'b000_0000_0010,
		ST_NUMBER    = 11'b000_0000_0100,
		ST_FLOAT     = 11'b000_0000_1000,
		ST_COMMENT   = 11'b000_0001_0000,
		ST_EXTFUN    = 11'b000_0010_0000,
		ST_LABEL     = 11'b000_0100_0000,
		ST_LOCAL     = 11'b000_1000_0000,
		ST_STRING    = 11'b001_0000_0000,
		ST_ESCAPE    = 11'b010_0000_0000,
		ST_DIRECTIVE = 11'b100_0000_0000
	} lex_state_t;

	// Outcome of one pass of the state machine over a character.
	typedef struct packed {
		logic        emit;
		logic [3:0]  kind;
		logic [7:0]  text;
		logic [2:0]  err;
		logic [23:0] line;
		lex_state_t  nxt;
		logic        reproc;
	} pass_t;

	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_FF     = 8'h0C;

	lex_state_t  state_q;
	logic [23:0] line_q;
	pass_t       p1;
	pass_t       p2;
	logic        e2;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic logic [23:0] line_inc(input logic [23:0] lc);
		return (lc == LINE_MAX) ? lc : lc + 24'd1;
	endfunction

	// One pass of the lexer state machine.
	function automatic pass_t lex_pass(input lex_state_t st, input logic [7:0] c,
			input logic eoi, input logic [23:0] lc);
		pass_t p;
		logic  alnum;
		alnum    = is_digit(c) || is_alpha(c);
		p.emit   = 1'b0;
		p.kind   = KIND_TEXT;
		p.text   = 8'h00;
		p.err    = ERR_NONE;
		p.line   = lc;
		p.nxt    = st;
		p.reproc = 1'b0;
		case (st)
			ST_READY: begin
				if (eoi) begin
					p.emit = 1'b1;
					p.kind = KIND_EOF;
				end else begin
					case (c)
						CH_LF: begin
							p.line = line_inc(lc);
							p.emit = 1'b1;
							p.kind = KIND_NEWLINE;
						end
						CH_BAR: begin
							p.emit = 1'b1;
							p.kind = KIND_NEWLINE;
						end
						CH_CR, CH_TAB, CH_SPACE: begin
							p.emit = 1'b0;
						end
						CH_SEMI:  p.nxt = ST_COMMENT;
						CH_BANG:  p.nxt = ST_EXTFUN;
						CH_QUOTE: p.nxt = ST_STRING;
						CH_HASH:  p.nxt = ST_DIRECTIVE;
						CH_AT: begin
							p.emit = 1'b1;
							p.text = c;
							p.nxt  = ST_LOCAL;
						end
						CH_UNDER: begin
							p.emit = 1'b1;
							p.text = c;
							p.nxt  = ST_LABEL;
						end
						default: begin
							p.emit = 1'b1;
							if (c == CH_MINUS || c == CH_PLUS || is_digit(c)) begin
								p.text = c;
								p.nxt  = ST_NUMBER;
							end else if (is_alpha(c)) begin
								p.text = c;
								p.nxt  = ST_IDENT;
							end else begin
								p.kind = KIND_ERROR;
								p.text = c;
								p.err  = ERR_UNDEF_CHAR;
							end
						end
					endcase
				end
			end
			ST_DIRECTIVE: begin
				if (eoi) begin
					p.nxt    = ST_READY;
					p.reproc = 1'b1;
				end else if (c == CH_LF) begin
					p.nxt = ST_READY;
				end
			end
			ST_COMMENT: begin
				if (eoi) begin
					p.nxt  = ST_READY;
					p.emit = 1'b1;
					p.kind = KIND_EOF;
				end else if (c == CH_LF) begin
					p.line = line_inc(lc);
					p.nxt  = ST_READY;
					p.emit = 1'b1;
					p.kind = KIND_NEWLINE;
				end
			end
			ST_EXTFUN: begin
				p.emit = 1'b1;
				if (!eoi && (c == CH_UNDER || alnum)) begin
					p.text = c;
				end else begin
					p.kind   = KIND_EXTFUN;
					p.nxt    = ST_READY;
					p.reproc = 1'b1;
				end
			end
			ST_NUMBER: begin
				p.emit = 1'b1;
				if (!eoi && is_digit(c)) begin
					p.text = c;
				end else if (!eoi && c == CH_DOT) begin
					p.text = c;
					p.nxt  = ST_FLOAT;
				end else begin
					p.kind   = KIND_INT;
					p.nxt    = ST_READY;
					p.reproc = 1'b1;
				end
			end
			ST_FLOAT: begin
				p.emit = 1'b1;
				if (!eoi && is_digit(c)) begin
					p.text = c;
				end else begin
					p.kind   = KIND_FLOAT;
					p.nxt    = ST_READY;
					p.reproc = 1'b1;
				end
			end
			ST_LABEL, ST_LOCAL: begin
				p.emit = 1'b1;
				if (!eoi && (alnum || c == CH_UNDER || c == CH_DOLLAR)) begin
					p.text = c;
				end else if (!eoi && c == CH_COLON) begin
					p.kind = (st == ST_LOCAL) ? KIND_LOCALDEF : KIND_LABELDEF;
					p.nxt  = ST_READY;
				end else begin
					p.kind   = (st == ST_LOCAL) ? KIND_LOCAL : KIND_LABEL;
					p.nxt    = ST_READY;
					p.reproc = 1'b1;
				end
			end
			ST_IDENT: begin
				p.emit = 1'b1;
				if (!eoi && alnum) begin
					p.text = c;
				end else begin
					p.kind   = KIND_IDENT;
					p.nxt    = ST_READY;
					p.reproc = 1'b1;
				end
			end
			ST_STRING: begin
				if (eoi || c == CH_LF) begin
					p.emit = 1'b1;
					p.kind = KIND_ERROR;
					p.err  = ERR_UNTERM_STR;
					p.nxt  = ST_READY;
				end else if (c == CH_BSLASH) begin
					p.nxt = ST_ESCAPE;
				end else if (c == CH_QUOTE) begin
					p.emit = 1'b1;
					p.kind = KIND_STRING;
					p.nxt  = ST_READY;
				end else begin
					p.emit = 1'b1;
					p.text = c;
				end
			end
			ST_ESCAPE: begin
				p.emit = 1'b1;
				if (eoi) begin
					p.kind = KIND_ERROR;
					p.err  = ERR_UNTERM_STR;
					p.nxt  = ST_READY;
				end else begin
					p.nxt = ST_STRING;
					case (c)
						CH_N:  p.text = CH_LF;
						CH_R:  p.text = CH_CR;
						CH_T:  p.text = CH_TAB;
						CH_B:  p.text = CH_BS;
						CH_F:  p.text = CH_FF;
						CH_LF: begin
							p.kind = KIND_ERROR;
							p.err  = ERR_ESC_NL;
							p.nxt  = ST_READY;
						end
						default: begin
							if (is_digit(c)) begin
								p.kind = KIND_ERROR;
								p.err  = ERR_OCTAL_ESC;
								p.nxt  = ST_READY;
							end else begin
								p.text = c;
							end
						end
					endcase
				end
			end
			default: begin
				p.nxt    = ST_READY;
				p.reproc = 1'b1;
			end
		endcase
		return p;
	endfunction

	// First pass in the current state, second pass in the ready state when
	// the character ended a token without being part of it.
	always_comb begin
		p1 = lex_pass(state_q, char_s1, eoi_s1, line_q);
		p2 = lex_pass(ST_READY, char_s1, eoi_s1, p1.line);
		e2 = p1.reproc && p2.emit;
	end

	// Pack the emitted results in order; the final one carries the last flag.
	always_comb begin
		push_cnt = 2'({1'b0, p1.emit} + {1'b0, e2});
		res0     = p1.emit ? {p1.kind, p1.text, p1.err, p1.line, 1'b0}
		                   : {p2.kind, p2.text, p2.err, p2.line, 1'b0};
		res0.last = !(p1.emit && e2);
		res1     = {p2.kind, p2.text, p2.err, p2.line, 1'b1};
		if (!consume) begin
			push_cnt = 2'd0;
		end
	end

	// State and line counter advance once per consumed character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_READY;
			line_q  <= 24'd1;
		end else if (consume) begin
			state_q <= p1.reproc ? p2.nxt : p1.nxt;
			line_q  <= p1.reproc ? p2.line : p1.line;
		end
	end

endmodule

[hdl/atl_result_fifo.sv]
// ----------------------------------------------------------------------------
// Assembler token lexer result queue
// Small flop-based queue that takes up to two results per cycle and hands
// one result per cycle to the output channel while pop is high.
// ----------------------------------------------------------------------------
module atl_result_fifo
	import atl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_cnt,
	input  result_t          din0,
	input  result_t          din1,
	input  logic             pop,
	output result_t          dout,
	output logic             not_empty,
	output logic [RQ_AW:0]   count
);

	result_t            mem_q [RQ_DEPTH];
	logic [RQ_AW-1:0]   wr_ptr_q;
	logic [RQ_AW-1:0]   rd_ptr_q;
	logic [RQ_AW:0]     count_q;
	logic [RQ_AW-1:0]   wr_ptr_p1;

	assign wr_ptr_p1 = wr_ptr_q + 1'b1;
	assign dout      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

	// Storage writes: first result at the write pointer, second one after it.
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= din0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_ptr_p1] <= din1;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RQ_AW'(push_cnt);
			rd_ptr_q <= rd_ptr_q + RQ_AW'(pop);
			count_q  <= count_q + (RQ_AW+1)'(push_cnt) - (RQ_AW+1)'(pop);
		end
	end

endmodule

[hdl/assembler_token_lexer.sv]
// ----------------------------------------------------------------------------
// Assembler token lexer
// Character-serial lexer for assembler source text with a result queue.
// ----------------------------------------------------------------------------
// One character transaction is taken per cycle. A character is captured in an
// input register, classified by the lexer state machine once it is consumed and
// its results (none, one, or two when a character ends a token and is then
// lexed again) are written to a four-entry result queue whose head drives the
// output ports, so each result passes the input register and the queue before
// it appears. The input channel stalls only while the queue could not take two
// more results; as long as the result side takes one transaction per cycle,
// the sustained rate is one character per cycle, and the extra result of a
// character that causes two results is absorbed by the queue.
module assembler_token_lexer
	import atl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  char_code,
	input  logic        end_of_input,
	output logic        token_valid,
	input  logic        token_stall,
	output logic [3:0]  token_kind,
	output logic [7:0]  text_char,
	output logic [2:0]  error_code,
	output logic [23:0] line_number,
	output logic        last
);

	logic           valid_s1;
	logic [7:0]     char_s1;
	logic           eoi_s1;
	logic           consume;
	logic           accept;
	logic           pop;
	logic [1:0]     push_cnt;
	logic [RQ_AW:0] rq_count;
	logic [RQ_AW:0] occ_after;
	result_t        res0;
	result_t        res1;
	result_t        head;

	// Handshake: the held character is consumed when the queue has room for
	// two results after this cycle's pop.
	assign pop        = token_valid && !token_stall;
	assign occ_after  = rq_count - (RQ_AW+1)'(pop);
	assign consume    = valid_s1 && (occ_after <= (RQ_AW+1)'(RQ_DEPTH - 2));
	assign char_stall = valid_s1 && !consume;
	assign accept     = char_valid && !char_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_code;
			eoi_s1  <= end_of_input;
		end
	end

	// Lexer state machine.
	atl_lex_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.consume  (consume),
		.char_s1  (char_s1),
		.eoi_s1   (eoi_s1),
		.push_cnt (push_cnt),
		.res0     (res0),
		.res1     (res1)
	);

	// Result queue feeding the output channel.
	atl_result_fifo u_rq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.din0      (res0),
		.din1      (res1),
		.pop       (pop),
		.dout      (head),
		.not_empty (token_valid),
		.count     (rq_count)
	);

	assign token_kind  = head.kind;
	assign text_char   = head.text;
	assign error_code  = head.err;
	assign line_number = head.line;
	assign last        = head.last;

endmodule

[hdl/atl_checker.sv]
// ----------------------------------------------------------------------------
// Assembler token lexer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module atl_checker
	import atl_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        token_valid,
	input logic        token_stall,
	input logic [3:0]  token_kind,
	input logic [7:0]  text_char,
	input logic [2:0]  error_code,
	input logic [23:0] line_number,
	input logic        last
);

	// A stalled result transaction stays offered.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_stall |=> token_valid)
		else $error("result valid dropped while stalled");

	// A stalled result transaction keeps its payload.
	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_stall |=> $stable(token_kind) && $stable(text_char)
			&& $stable(error_code) && $stable(line_number) && $stable(last))
		else $error("result payload changed while stalled");

	// An error code is present exactly on error results.
	a_error_code: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid |-> ((token_kind == KIND_ERROR) == (error_code != ERR_NONE)))
		else $error("error code does not match token kind");

	// Only text and error results may carry a character.
	a_text_zero: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_kind != KIND_TEXT && token_kind != KIND_ERROR
			|-> text_char == 8'h00)
		else $error("token announcement carries a character");

	// Line numbers never go backward across delivered results.
	a_line_order: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && $past(token_valid && !token_stall)
			|-> line_number >= $past(line_number))
		else $error("line number decreased");

endmodule

bind assembler_token_lexer atl_checker u_atl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.token_valid (token_valid),
	.token_stall (token_stall),
	.token_kind  (token_kind),
	.text_char   (text_char),
	.error_code  (error_code),
	.line_number (line_number),
	.last        (last)
);
